/* src/ceregs_pkg.sv */
package ceregs_pkg;

  localparam int unsigned WADDR_W = 12;

  // Word offsets with a special meaning.
  localparam logic [WADDR_W-1:0] W_STATUS     = 12'd0;
  localparam logic [WADDR_W-1:0] W_CTRL       = 12'd1;
  localparam logic [WADDR_W-1:0] W_RES_ADDR   = 12'd14;
  localparam logic [WADDR_W-1:0] W_RES_LEN    = 12'd15;
  localparam logic [WADDR_W-1:0] W_INT_CLR    = 12'd17;
  localparam logic [WADDR_W-1:0] W_INT_SET    = 12'd18;
  localparam logic [WADDR_W-1:0] W_ERR_STATUS = 12'd19;
  localparam logic [WADDR_W-1:0] W_ERR_CLR    = 12'd20;
  localparam logic [WADDR_W-1:0] W_VERSION    = 12'd21;
  localparam logic [WADDR_W-1:0] W_RND_DATA   = 12'd23;
  localparam logic [WADDR_W-1:0] W_CRC        = 12'd25;
  localparam logic [WADDR_W-1:0] W_FIN_ADDR   = 12'd28;
  localparam logic [WADDR_W-1:0] W_KS_FIRST   = 12'd84;
  localparam logic [WADDR_W-1:0] W_KS_LAST    = 12'd103;

  localparam logic [31:0] STATUS_BASE = 32'h0000_0308;
  localparam logic [31:0] VERSION_VAL = 32'h0000_1000;
  localparam logic [31:0] PRNG_SEED   = 32'h2545_F491;

  // Command codes of the control register.
  localparam logic [4:0] CMD_RND_BYTES = 5'd24;
  localparam logic [4:0] CMD_HK_A      = 5'd11;
  localparam logic [4:0] CMD_HK_B      = 5'd25;
  localparam logic [4:0] CMD_HK_C      = 5'd28;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic clear;
    logic dma_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_read;
    logic start_dma;
    logic out_free;
    logic left_zero;
  } dp_stat_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

/* src/ceregs_ctrl.sv */
module ceregs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  ceregs_pkg::dp_stat_t stat,
  output ceregs_pkg::dp_cmd_t  cmd
);

  ceregs_pkg::state_t state;
  ceregs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ceregs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ceregs_pkg::ST_CLEAR: begin
        if (stat.clear_done) state_next = ceregs_pkg::ST_IDLE;
      end
      ceregs_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = ceregs_pkg::ST_EXEC;
      end
      ceregs_pkg::ST_EXEC: begin
        if (stat.is_read || stat.start_dma) begin
          state_next = ceregs_pkg::ST_DRAIN;
        end else begin
          state_next = ceregs_pkg::ST_IDLE;
        end
      end
      ceregs_pkg::ST_DRAIN: begin
        if (stat.out_free && stat.left_zero) state_next = ceregs_pkg::ST_IDLE;
      end
      default: state_next = ceregs_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ceregs_pkg::ST_CLEAR: cmd.clear  = 1'b1;
      ceregs_pkg::ST_IDLE:  cmd.accept = 1'b1;
      ceregs_pkg::ST_EXEC:  cmd.exec   = 1'b1;
      ceregs_pkg::ST_DRAIN: cmd.dma_load = stat.out_free && !stat.left_zero;
      default: cmd = '0;
    endcase
  end

endmodule

/* src/ceregs_dp.sv */
module ceregs_dp #(
  parameter int unsigned REG_WORDS     = 128,
  parameter int unsigned RND_MAX_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ceregs_pkg::dp_cmd_t cmd,
  output ceregs_pkg::dp_stat_t stat,
  input  logic                s_tvalid,
  input  logic [47:0]         s_tdata,
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [63:0]         m_tdata,
  output logic                m_tuser,
  output logic                m_tlast
);

  localparam int unsigned AW = $clog2(REG_WORDS);
  localparam int unsigned CW = $clog2(RND_MAX_BYTES + 1);

  logic [31:0] mem [REG_WORDS];
  logic [31:0] rd_data;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;

  logic [AW-1:0] clr_cnt;

  // Captured bus access.
  logic        op;
  logic [ceregs_pkg::WADDR_W-1:0] waddr;
  logic [31:0] wdata;

  // Shadows of the result address and length words.
  logic [31:0] res_addr;
  logic [31:0] res_len;

  logic [31:0] prng;
  logic [31:0] prng_adv;
  logic        op_error;
  logic        op_error_next;

  logic [31:0] dma_addr;
  logic [CW-1:0] left;

  logic        out_valid;
  logic [31:0] out_addr;
  logic [31:0] out_data;
  logic        out_kind;
  logic        out_last;

  logic        in_range;
  logic        read_only;
  logic        wr_ok;
  logic        store;
  logic        ctrl_wr;
  logic        run_cmd;
  logic [4:0]  cmd_code;
  logic        len_bad;
  logic        start_dma;
  logic [31:0] read_val;

  assign prng_adv = ceregs_pkg::xorshift32(prng);

  always_comb begin
    in_range  = waddr < ceregs_pkg::WADDR_W'(REG_WORDS);
    read_only = (waddr inside {ceregs_pkg::W_STATUS, ceregs_pkg::W_ERR_STATUS,
                               ceregs_pkg::W_VERSION, ceregs_pkg::W_RND_DATA,
                               ceregs_pkg::W_CRC, ceregs_pkg::W_FIN_ADDR,
                               [ceregs_pkg::W_KS_FIRST:ceregs_pkg::W_KS_LAST]});
    wr_ok     = (op == ceregs_pkg::OP_WRITE) && in_range && !read_only;
    store     = wr_ok && !(waddr inside {ceregs_pkg::W_INT_CLR, ceregs_pkg::W_INT_SET,
                                         ceregs_pkg::W_ERR_CLR});
    ctrl_wr   = wr_ok && (waddr == ceregs_pkg::W_CTRL);
    run_cmd   = ctrl_wr && !wdata[2] && wdata[0] && wdata[1];
    cmd_code  = wdata[7:3];
    len_bad   = (res_len == 32'd0) || (res_len > 32'(RND_MAX_BYTES));
    start_dma = run_cmd && (cmd_code == ceregs_pkg::CMD_RND_BYTES) && !len_bad;
  end

  always_comb begin
    op_error_next = op_error;
    if (wr_ok && waddr == ceregs_pkg::W_ERR_CLR && wdata[1]) begin
      op_error_next = 1'b0;
    end else if (ctrl_wr && wdata[2]) begin
      op_error_next = 1'b0;
    end else if (run_cmd) begin
      case (cmd_code)
        ceregs_pkg::CMD_RND_BYTES: begin
          if (len_bad) op_error_next = 1'b1;
        end
        ceregs_pkg::CMD_HK_A, ceregs_pkg::CMD_HK_B, ceregs_pkg::CMD_HK_C: begin
          op_error_next = op_error;
        end
        default: op_error_next = 1'b1;
      endcase
    end
  end

  always_comb begin
    case (waddr)
      ceregs_pkg::W_STATUS:     read_val = ceregs_pkg::STATUS_BASE | {29'd0, op_error, 2'd0};
      ceregs_pkg::W_ERR_STATUS: read_val = {30'd0, op_error, 1'b0};
      ceregs_pkg::W_VERSION:    read_val = ceregs_pkg::VERSION_VAL;
      ceregs_pkg::W_RND_DATA:   read_val = prng_adv;
      ceregs_pkg::W_INT_CLR,
      ceregs_pkg::W_INT_SET,
      ceregs_pkg::W_ERR_CLR:    read_val = 32'd0;
      default:                  read_val = in_range ? rd_data : 32'd0;
    endcase
  end

  // Single write port shared by the clearing pass and stores.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = waddr[AW-1:0];
    mem_wd = wdata;
    if (cmd.clear) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
      mem_wd = 32'd0;
    end else if (cmd.exec && store) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[s_tdata[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear && clr_cnt != AW'(REG_WORDS - 1)) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && s_tvalid) begin
      op    <= s_tuser;
      waddr <= s_tdata[ceregs_pkg::WADDR_W-1:0];
      wdata <= s_tdata[ceregs_pkg::WADDR_W +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_addr <= 32'd0;
      res_len  <= 32'd0;
      prng     <= ceregs_pkg::PRNG_SEED;
      op_error <= 1'b0;
      left     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        op_error <= op_error_next;
        if (wr_ok && waddr == ceregs_pkg::W_RES_ADDR) res_addr <= wdata;
        if (wr_ok && waddr == ceregs_pkg::W_RES_LEN)  res_len  <= wdata;
        if (start_dma) left <= CW'(res_len);
        if (op == ceregs_pkg::OP_READ && waddr == ceregs_pkg::W_RND_DATA) prng <= prng_adv;
      end else if (cmd.dma_load) begin
        prng <= prng_adv;
        left <= left - 1'b1;
      end
      if ((cmd.exec && op == ceregs_pkg::OP_READ) || cmd.dma_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && start_dma) begin
      dma_addr <= res_addr;
    end else if (cmd.dma_load) begin
      dma_addr <= dma_addr + 32'd1;
    end
    if (cmd.exec && op == ceregs_pkg::OP_READ) begin
      out_kind <= 1'b0;
      out_addr <= 32'd0;
      out_data <= read_val;
      out_last <= 1'b1;
    end else if (cmd.dma_load) begin
      out_kind <= 1'b1;
      out_addr <= dma_addr;
      out_data <= {24'd0, prng_adv[7:0]};
      out_last <= (left == CW'(1));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_data, out_addr};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  always_comb begin
    stat.clear_done = (clr_cnt == AW'(REG_WORDS - 1));
    stat.is_read    = (op == ceregs_pkg::OP_READ);
    stat.start_dma  = start_dma;
    stat.out_free   = !out_valid || m_tready;
    stat.left_zero  = (left == '0);
  end

endmodule

/* src/crypto_engine_register_stub_unit.sv */
// Channel | Direction | tdata (low bit up)                     | tuser     | tlast
// s_*     | in        | word_address[11:0], write_data[43:12]  | operation | -
// m_*     | out       | dma_address[31:0], data[63:32]         | kind      | last
//
// One access at a time: accept, an execute state (register file read lands),
// then a read reply or 1..RND_MAX_BYTES DMA byte transfers, one per cycle while
// m_tready holds. After reset a clearing pass zeroes the register file;
// s_tready stays low meanwhile. Output stalls hold the current transfer.
module crypto_engine_register_stub_unit #(
  parameter int unsigned REG_WORDS     = 128,
  parameter int unsigned RND_MAX_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // word_address, write_data, zero pad
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // dma_address, data
  output logic        m_tuser,   // kind
  output logic        m_tlast
);

  ceregs_pkg::dp_cmd_t  cmd;
  ceregs_pkg::dp_stat_t stat;

  ceregs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  ceregs_dp #(
    .REG_WORDS     (REG_WORDS),
    .RND_MAX_BYTES (RND_MAX_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign s_tready = cmd.accept;

endmodule

/* test/crypto_engine_register_stub_unit_checker.sv */
`timescale 1ns / 100ps

module crypto_engine_register_stub_unit_checker #(
  parameter int unsigned REG_WORDS     = 128,
  parameter int unsigned RND_MAX_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // word_address, write_data, zero pad
  input  logic        s_tuser,   // operation
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // dma_address, data
  input  logic        m_tuser,   // kind
  input  logic        m_tlast,
  output int          failures,
  output int          pending,
  output int          dma_seen
);

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_DMA   = 1'b1;

  localparam int STATUS_ERR_BIT = 2;
  localparam int ERRSTAT_BIT    = 1;
  localparam int ERRCLR_BIT     = 1;
  localparam int CTRL_ENABLE    = 0;
  localparam int CTRL_START     = 1;
  localparam int CTRL_ERR_RESET = 2;

  typedef struct packed {
    logic        kind;
    logic [31:0] dma_address;
    logic [31:0] data;
    logic        last;
  } bus_result_t;

  bus_result_t expected_results[$];

  logic [31:0] reg_shadow [0:REG_WORDS-1];
  logic [31:0] rng_word;
  logic        err_flag;

  function automatic logic [31:0] step_rng();
    logic [31:0] x;
    x = rng_word;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    rng_word = x;
    return x;
  endfunction

  function automatic logic is_protected(input logic [11:0] w);
    return w == ceregs_pkg::W_STATUS || w == ceregs_pkg::W_ERR_STATUS ||
           w == ceregs_pkg::W_VERSION || w == ceregs_pkg::W_RND_DATA ||
           w == ceregs_pkg::W_CRC || w == ceregs_pkg::W_FIN_ADDR ||
           (w >= ceregs_pkg::W_KS_FIRST && w <= ceregs_pkg::W_KS_LAST);
  endfunction

  function automatic logic [31:0] read_value(input logic [11:0] w);
    logic [31:0] v;
    v = '0;
    case (w)
      ceregs_pkg::W_STATUS: begin
        v = ceregs_pkg::STATUS_BASE;
        v[STATUS_ERR_BIT] = err_flag;
      end
      ceregs_pkg::W_ERR_STATUS: v[ERRSTAT_BIT] = err_flag;
      ceregs_pkg::W_VERSION: v = ceregs_pkg::VERSION_VAL;
      ceregs_pkg::W_RND_DATA: v = step_rng();
      ceregs_pkg::W_INT_CLR, ceregs_pkg::W_INT_SET, ceregs_pkg::W_ERR_CLR: v = '0;
      default: if (w < REG_WORDS) v = reg_shadow[w];
    endcase
    return v;
  endfunction

  // Random bytes go out one per transfer, the generator stepped once per byte.
  task automatic emit_random_bytes();
    bus_result_t r;
    logic [31:0] base;
    logic [31:0] len;
    logic [31:0] rnd_word;
    base = reg_shadow[ceregs_pkg::W_RES_ADDR];
    len = reg_shadow[ceregs_pkg::W_RES_LEN];
    if (len == 0 || len > RND_MAX_BYTES) begin
      err_flag = 1'b1;
    end else begin
      for (logic [31:0] n = 0; n < len; n++) begin
        rnd_word = step_rng();
        r.kind = KIND_DMA;
        r.dma_address = base + n;
        r.data = {24'h0, rnd_word[7:0]};
        r.last = (n + 1 == len);
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic take_access(input logic op, input logic [11:0] w, input logic [31:0] val);
    bus_result_t r;
    logic [4:0] cmd;
    if (op == ceregs_pkg::OP_READ) begin
      r.kind = KIND_REPLY;
      r.dma_address = '0;
      r.data = read_value(w);
      r.last = 1'b1;
      expected_results.push_back(r);
    end else if (w < REG_WORDS && !is_protected(w)) begin
      case (w)
        ceregs_pkg::W_ERR_CLR: if (val[ERRCLR_BIT]) err_flag = 1'b0;
        ceregs_pkg::W_INT_CLR, ceregs_pkg::W_INT_SET: ;
        ceregs_pkg::W_CTRL: begin
          reg_shadow[ceregs_pkg::W_CTRL] = val;
          cmd = val[7:3];
          if (val[CTRL_ERR_RESET]) begin
            err_flag = 1'b0;
          end else if (val[CTRL_ENABLE] && val[CTRL_START]) begin
            if (cmd == ceregs_pkg::CMD_RND_BYTES) emit_random_bytes();
            else if (cmd != ceregs_pkg::CMD_HK_A && cmd != ceregs_pkg::CMD_HK_B &&
                     cmd != ceregs_pkg::CMD_HK_C) err_flag = 1'b1;
          end
        end
        default: reg_shadow[w] = val;
      endcase
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (failures < 40)
      $display("%0t: %s", $realtime, msg);
    failures++;
  endtask

  task automatic check_transfer();
    bus_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result transfer, tdata %h", m_tdata));
    end else begin
      want = expected_results.pop_front();
      if (m_tuser !== want.kind)
        report_mismatch($sformatf("kind mismatch, got %h expected %h", m_tuser, want.kind));
      if (m_tdata[31:0] !== want.dma_address)
        report_mismatch($sformatf("dma_address mismatch, got %h expected %h",
                                  m_tdata[31:0], want.dma_address));
      if (m_tdata[63:32] !== want.data)
        report_mismatch($sformatf("data mismatch, got %h expected %h",
                                  m_tdata[63:32], want.data));
      if (m_tlast !== want.last)
        report_mismatch($sformatf("last mismatch, got %h expected %h", m_tlast, want.last));
      if (want.kind == KIND_DMA) dma_seen++;
    end
  endtask

  initial begin
    failures = 0;
    dma_seen = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_WORDS; i++) reg_shadow[i] = '0;
      rng_word = ceregs_pkg::PRNG_SEED;
      err_flag = 1'b0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) take_access(s_tuser, s_tdata[11:0], s_tdata[43:12]);
      if (m_tvalid && m_tready) check_transfer();
      pending <= expected_results.size();
    end
  end

endmodule

/* test/crypto_engine_register_stub_unit_test.sv */
`timescale 1ns / 100ps

module crypto_engine_register_stub_unit_test;

  localparam int unsigned REG_WORDS     = 128;
  localparam int unsigned RND_MAX_BYTES = 64;

  localparam int CTRL_ERR_RESET = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // word_address, write_data, zero pad
  logic        s_tuser = 1'b0; // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // dma_address, data
  logic        m_tuser;        // kind
  logic        m_tlast;

  int failures;
  int pending;
  int dma_seen;
  int reads = 0;
  int writes = 0;
  logic calm = 1'b0;

  crypto_engine_register_stub_unit #(
    .REG_WORDS(REG_WORDS),
    .RND_MAX_BYTES(RND_MAX_BYTES)
  ) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  crypto_engine_register_stub_unit_checker #(
    .REG_WORDS(REG_WORDS),
    .RND_MAX_BYTES(RND_MAX_BYTES)
  ) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .failures(failures), .pending(pending), .dma_seen(dma_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_cycles();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Every task below starts and ends at a rising edge.
  task automatic post_access(input logic op, input logic [11:0] w, input logic [31:0] val);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'h0, val, w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == ceregs_pkg::OP_READ) reads++;
    else writes++;
  endtask

  task automatic bus_read(input logic [11:0] w);
    post_access(ceregs_pkg::OP_READ, w, $urandom);
  endtask

  task automatic bus_write(input logic [11:0] w, input logic [31:0] val);
    post_access(ceregs_pkg::OP_WRITE, w, val);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Command field, enable and start set, error reset clear, the rest of the word random.
  function automatic logic [31:0] command_word(input logic [4:0] cmd);
    logic [31:0] v;
    v = $urandom;
    v[7:3] = cmd;
    v[CTRL_ERR_RESET] = 1'b0;
    v[1:0] = 2'b11;
    return v;
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 15))
      0: return 0;
      1: return RND_MAX_BYTES + 1 + $urandom_range(0, 100);
      2: return $urandom;
      3: return RND_MAX_BYTES;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [11:0] pick_special();
    case ($urandom_range(0, 13))
      0: return ceregs_pkg::W_STATUS;
      1: return ceregs_pkg::W_CTRL;
      2: return ceregs_pkg::W_RES_ADDR;
      3: return ceregs_pkg::W_RES_LEN;
      4: return ceregs_pkg::W_INT_CLR;
      5: return ceregs_pkg::W_INT_SET;
      6: return ceregs_pkg::W_ERR_STATUS;
      7: return ceregs_pkg::W_ERR_CLR;
      8: return ceregs_pkg::W_VERSION;
      9: return ceregs_pkg::W_RND_DATA;
      10: return ceregs_pkg::W_CRC;
      11: return ceregs_pkg::W_FIN_ADDR;
      default: return ceregs_pkg::W_KS_FIRST +
                      12'($urandom_range(0, ceregs_pkg::W_KS_LAST - ceregs_pkg::W_KS_FIRST));
    endcase
  endfunction

  initial begin
    #5_000_000;
    $display("crypto_engine_register_stub_unit test failed");
    $finish;
  end

  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    int iter;
    logic [11:0] w;
    logic paused;
    iter = 0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: fixed readings, the error flag, the random-bytes limits.
    bus_read(ceregs_pkg::W_STATUS);
    bus_read(ceregs_pkg::W_VERSION);
    bus_read(ceregs_pkg::W_RND_DATA);
    bus_write(ceregs_pkg::W_STATUS, 32'hFFFF_FFFF);
    bus_write(ceregs_pkg::W_CTRL, 32'h0000_0003);
    bus_read(ceregs_pkg::W_STATUS);
    bus_write(ceregs_pkg::W_ERR_CLR, 32'hFFFF_FFFD);
    bus_read(ceregs_pkg::W_ERR_STATUS);
    bus_write(ceregs_pkg::W_ERR_CLR, 32'h0000_0002);
    // A full-length burst whose buffer address wraps past the top.
    bus_write(ceregs_pkg::W_RES_ADDR, 32'hFFFF_FFFE);
    bus_write(ceregs_pkg::W_RES_LEN, RND_MAX_BYTES);
    bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_RND_BYTES));
    bus_write(ceregs_pkg::W_RES_LEN, RND_MAX_BYTES + 1);
    bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_RND_BYTES));
    bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_RND_BYTES) | 32'h4);
    bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_HK_A));
    bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_HK_B));
    bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_HK_C));
    bus_read(ceregs_pkg::W_ERR_STATUS);
    bus_write(ceregs_pkg::W_RES_LEN, 32'h0);
    bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_RND_BYTES));
    bus_write(12'hFFF, 32'hFFFF_FFFF);
    bus_read(12'hFFF);
    bus_write(ceregs_pkg::W_KS_LAST, 32'hFFFF_FFFF);
    bus_read(ceregs_pkg::W_KS_LAST);
    bus_write(12'd127, 32'hFFFF_FFFF);
    bus_read(12'd127);
    drain_results();

    // Random part: complete random-bytes sequences in three of ten picks, the rest loose accesses.
    while (reads + writes < 130) begin
      if (iter % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      if (!paused && reads + writes > 100) begin
        drain_results();
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          bus_write(ceregs_pkg::W_RES_ADDR, $urandom);
          bus_write(ceregs_pkg::W_RES_LEN, pick_length());
          bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_RND_BYTES));
          if ($urandom_range(0, 1)) bus_read(ceregs_pkg::W_RND_DATA);
        end
        3: bus_read(pick_special());
        4: begin
          w = 12'($urandom_range(0, REG_WORDS - 1));
          bus_write(w, $urandom);
          bus_read(w);
        end
        5: post_access(1'($urandom_range(0, 1)), 12'($urandom), $urandom);
        6: bus_write(ceregs_pkg::W_CTRL, $urandom);
        7: begin
          case ($urandom_range(0, 3))
            0: bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_HK_A));
            1: bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_HK_B));
            2: bus_write(ceregs_pkg::W_CTRL, command_word(ceregs_pkg::CMD_HK_C));
            default: bus_write(ceregs_pkg::W_CTRL, command_word(5'($urandom)));
          endcase
          bus_read(ceregs_pkg::W_STATUS);
        end
        8: begin
          if ($urandom_range(0, 1)) bus_write(ceregs_pkg::W_ERR_CLR, $urandom);
          else bus_write(ceregs_pkg::W_CTRL, $urandom | 32'h4);
          bus_read(ceregs_pkg::W_ERR_STATUS);
        end
        default: bus_read(12'($urandom_range(0, REG_WORDS - 1)));
      endcase
      iter++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Covered %0d reads and %0d writes with %0d random byte transfers.",
             reads, writes, dma_seen);
    if (failures == 0) begin
      $display("crypto_engine_register_stub_unit test passed");
    end else begin
      $display("crypto_engine_register_stub_unit test failed");
    end
    $finish;
  end

endmodule
